/* rtl/rlsu_pkg.sv */
// ----------------------------------------------------------------------------
// RGB line-stream unpacker package
// Shared widths, register codes, pixel phase codes and the word types that
// the unpacker's modules pass between them.
// ----------------------------------------------------------------------------
package rlsu_pkg;

    localparam int DATA_W      = 8;
    localparam int COORD_W     = 11;
    localparam int INDEX_W     = 21;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int LIMIT_W     = 13;

    // Default image limits, handed to the top level's parameters.
    localparam int MAX_COLS_DEFAULT = 1920;
    localparam int MAX_ROWS_DEFAULT = 1080;

    // Register reset values.
    localparam logic [COORD_W-1:0] WIDTH_RESET  = 11'd1920;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 11'd1080;

    // A byte of this value at a pixel boundary ends the current line.
    localparam logic [DATA_W-1:0] LINE_END_BYTE = 8'h0B;

    // Configuration register indices.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Which byte of a pixel is expected next.
    typedef enum logic [2:0] {
        PH_RED   = 3'b001,
        PH_GREEN = 3'b010,
        PH_BLUE  = 3'b100
    } phase_t;

    // One input word.
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              chunk_end;
        logic              frame_end;
    } in_t;

    // One result word.
    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic [DATA_W-1:0]  red;
        logic [DATA_W-1:0]  green;
        logic [DATA_W-1:0]  blue;
    } out_t;

    // Effective image size after clamping to the build limits.
    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } geom_t;

    // A completed in-image pixel on its way to the output register.
    typedef struct packed {
        logic               fire;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [DATA_W-1:0]  red;
        logic [DATA_W-1:0]  green;
        logic [DATA_W-1:0]  blue;
    } cand_t;

endpackage

/* rtl/rlsu_cfg.sv */
// ----------------------------------------------------------------------------
// RGB line-stream unpacker configuration registers
// Holds the image width and height and clamps them to the build limits.
// ----------------------------------------------------------------------------
module rlsu_cfg #(
    parameter int MAX_COLS = rlsu_pkg::MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = rlsu_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [rlsu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rlsu_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rlsu_pkg::geom_t                  geom
);
    import rlsu_pkg::*;

    localparam logic [LIMIT_W-1:0] MaxColsV = LIMIT_W'(MAX_COLS);
    localparam logic [LIMIT_W-1:0] MaxRowsV = LIMIT_W'(MAX_ROWS);

    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] height_reg;
    logic               width_below;
    logic               height_below;

    // Register writes, decoded by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[COORD_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[COORD_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp to the limits. When a limit is taken it is no larger than the
    // register value, so it always fits the coordinate width.
    assign width_below  = {{(LIMIT_W-COORD_W){1'b0}}, width_reg}  < MaxColsV;
    assign height_below = {{(LIMIT_W-COORD_W){1'b0}}, height_reg} < MaxRowsV;

    assign geom.width  = width_below  ? width_reg  : MaxColsV[COORD_W-1:0];
    assign geom.height = height_below ? height_reg : MaxRowsV[COORD_W-1:0];

endmodule

/* rtl/rlsu_parse.sv */
// ----------------------------------------------------------------------------
// RGB line-stream unpacker byte parser
// Tracks the pixel phase, column and row, gathers three bytes into a pixel
// and flags the pixels that fall inside the image.
// ----------------------------------------------------------------------------
module rlsu_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  rlsu_pkg::in_t   in_word,
    input  rlsu_pkg::geom_t geom,
    output rlsu_pkg::cand_t cand
);
    import rlsu_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] col_next;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] row_next;
    logic [DATA_W-1:0]  red_reg;
    logic [DATA_W-1:0]  red_next;
    logic [DATA_W-1:0]  green_reg;
    logic [DATA_W-1:0]  green_next;
    logic               start;
    logic               finish;
    logic               col_inside;
    logic               row_inside;

    assign col_inside = col_reg < geom.width;
    assign row_inside = row_reg < geom.height;

    // Next position and phase for the byte on the input.
    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        red_next   = red_reg;
        green_next = green_reg;
        start      = 1'b0;
        finish     = 1'b0;

        case (phase_reg)
            PH_RED:   start = 1'b1;
            PH_GREEN:
            begin
                green_next = in_word.data_byte;
                phase_next = PH_BLUE;
            end
            PH_BLUE:  finish = 1'b1;
            default:  start = 1'b1;
        endcase

        // At a pixel boundary: either a line end or the red byte.
        if (start)
        begin
            if (in_word.data_byte == LINE_END_BYTE)
            begin
                col_next = '0;
                if (row_inside)
                begin
                    row_next = row_reg + COORD_W'(1);
                end
            end
            else
            begin
                red_next   = in_word.data_byte;
                phase_next = PH_GREEN;
            end
        end

        // The blue byte completes the pixel; the column saturates at the width.
        if (finish)
        begin
            if (col_inside)
            begin
                col_next = col_reg + COORD_W'(1);
            end
            phase_next = PH_RED;
        end

        // A chunk end drops an unfinished pixel; a frame end restarts the image.
        if (in_word.chunk_end)
        begin
            phase_next = PH_RED;
        end
        if (in_word.frame_end)
        begin
            col_next   = '0;
            row_next   = '0;
            phase_next = PH_RED;
        end
    end

    // Position and phase registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RED;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // Colour holding registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
        end
    end

    // The finished pixel, flagged only when it lies inside the image.
    assign cand.fire   = take && finish && col_inside && row_inside;
    assign cand.column = col_reg;
    assign cand.row    = row_reg;
    assign cand.red    = red_reg;
    assign cand.green  = green_reg;
    assign cand.blue   = in_word.data_byte;

endmodule

/* rtl/rlsu_outbuf.sv */
// ----------------------------------------------------------------------------
// RGB line-stream unpacker output register
// Forms the linear pixel index and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module rlsu_outbuf (
    input  logic               clk,
    input  logic               rst_n,
    input  rlsu_pkg::cand_t    cand,
    input  logic [rlsu_pkg::COORD_W-1:0] width,
    input  logic               out_ready,
    output logic               out_valid,
    output rlsu_pkg::out_t     out_data,
    output logic               room
);
    import rlsu_pkg::*;

    logic [2*COORD_W-1:0] row_base;
    logic [INDEX_W-1:0]   index_next;
    logic                 valid_reg;
    out_t                 data_reg;

    // Row times width plus column, kept to the index width.
    assign row_base   = (2*COORD_W)'(cand.row) * (2*COORD_W)'(width);
    assign index_next = row_base[INDEX_W-1:0] + INDEX_W'(cand.column);

    // The register can take a new word when empty or being emptied.
    assign room = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cand.fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand.fire)
        begin
            data_reg.pixel_index  <= index_next;
            data_reg.pixel_column <= cand.column;
            data_reg.pixel_row    <= cand.row;
            data_reg.red          <= cand.red;
            data_reg.green        <= cand.green;
            data_reg.blue         <= cand.blue;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/rgb_line_stream_unpacker_core.sv */
// A pixel appears on out_valid in the cycle after its blue byte is accepted.
// Throughput: one byte per cycle while in_ready is high; the output register parts the two channels.
// in_ready falls only while a result waits in the output register and out_ready is low.
// Reset (rst_n, asynchronous, active low) clears position, phase and the output
// valid flag, and sets the image size to 1920 by 1080.
// ----------------------------------------------------------------------------
// RGB line-stream unpacker
// Unpacks a stream of payload bytes into RGB pixels with their position and
// linear index, handling line ends, chunk ends and frame ends.
// ----------------------------------------------------------------------------
module rgb_line_stream_unpacker_core #(
    parameter int MAX_COLS = rlsu_pkg::MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = rlsu_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  rlsu_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output rlsu_pkg::out_t                   out_data,
    input  logic                             cfg_wen,
    input  logic [rlsu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rlsu_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rlsu_pkg::*;

    geom_t geom;
    cand_t cand;
    logic  room;
    logic  take;

    assign in_ready = room;
    assign take     = in_valid && room;

    // Image size registers.
    rlsu_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // Byte parser and position tracking.
    rlsu_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_word (in_data),
        .geom    (geom),
        .cand    (cand)
    );

    // Index calculation and result register.
    rlsu_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .cand      (cand),
        .width     (geom.width),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .room      (room)
    );

endmodule

/* rtl/rlsu_checker.sv */
// ----------------------------------------------------------------------------
// RGB line-stream unpacker port checker
// Watches the top level's ports for output ordering and back-pressure slips.
// ----------------------------------------------------------------------------
module rlsu_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input rlsu_pkg::in_t                    in_data,
    input logic                             out_valid,
    input logic                             out_ready,
    input rlsu_pkg::out_t                   out_data
);
    import rlsu_pkg::*;

    logic in_take;
    logic out_stall;

    assign in_take   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // A stalled result word holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    // A result only follows an accepted byte or a held word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_take && !out_stall |=> !out_valid)
        else $error("result word without a source");

    // Input stalls only while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_stall)
        else $error("input stalled with no waiting result");

    // A fresh result carries the byte accepted just before as its blue value.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall ##1 out_valid |-> out_data.blue == $past(in_data.data_byte))
        else $error("blue value does not match the completing byte");

endmodule

bind rgb_line_stream_unpacker_core rlsu_checker u_rlsu_checker (.*);
